// ----- design/ets_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ets_pkg: shared constants for the exponential series core
// widths and fixed-point settings for the running-term series evaluator
// ----------------------------------------------------------------------------
package ets_pkg;

	// fixed-point and series limits
	localparam int FRAC_BITS = 12;
	localparam int MAX_TERMS = 31;

	// field widths
	localparam int X_W   = 16;
	localparam int SUM_W = 32;
	localparam int TC_W  = 5;

	// register reset value of the term count
	localparam logic [TC_W-1:0] TC_RESET = TC_W'(10);

	// running term magnitude, product and divider widths
	localparam int MAG_W    = SUM_W;
	localparam int XMAG_W   = X_W;
	localparam int PROD_W   = MAG_W + XMAG_W;
	localparam int RND_W    = PROD_W + 1;
	localparam int QRAW_W   = RND_W - FRAC_BITS;
	localparam int DIV_STEP = 4;
	localparam int DIV_CYC  = (QRAW_W + DIV_STEP - 1) / DIV_STEP;
	localparam int DVD_W    = DIV_CYC * DIV_STEP;
	localparam int DCNT_W   = $clog2(DIV_CYC + 1);

	// term index counter
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int CMP_W = (TC_W > CNT_W) ? TC_W : CNT_W;

	// one in the fixed-point format
	localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

endpackage

// ----- design/exp_taylor_series_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_taylor_series_core: truncated taylor series of e^x in fixed point
// one shared multiplier and a radix-2 divider build term = term * x / c
// ----------------------------------------------------------------------------
// usage
//   input request: x_value (signed q4.12) on in_valid, taken when in_stall
//   is low. in_stall stays high from the cycle after a request is taken
//   until the result has been moved into the output register.
//   output request: exp_sum (signed q20.12, saturated) and saturated on
//   out_valid, taken when out_stall is low. the output register holds a
//   finished result while the receiver stalls, and a new input request is
//   taken meanwhile; a second result then waits in the sequencer until the
//   output register is free.
//   configuration: term_count on cfg_valid / cfg_ready, always ready. write
//   it only while the block is idle.
// sequence
//   each series term runs through one multiply, one round-and-load, the
//   divider iterations at four quotient bits a cycle and one update of term
//   and sum. an item with N terms runs N such terms before its result goes
//   to the output register, and at N = 0 it goes straight to the output
//   step; the next request is taken only after that, so items do not overlap.
// reset
//   arst_n clears the sequencer and output valid, and sets term_count to 10.
// ----------------------------------------------------------------------------
module exp_taylor_series_core (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [ets_pkg::X_W-1:0]    x_value,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [ets_pkg::SUM_W-1:0]  exp_sum,
	output logic                              saturated,
	// configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic        [ets_pkg::TC_W-1:0]   term_count
);

	import ets_pkg::*;

	// sequencer codes
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	// clamp limits on the quotient magnitude and on the sum
	localparam logic [DVD_W-1:0] Q_POS_MAX = DVD_W'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic [DVD_W-1:0] Q_NEG_MAX = DVD_W'({1'b1, {(SUM_W-1){1'b0}}});
	localparam logic signed [SUM_W+1:0] S_MAX = (SUM_W+2)'({1'b0, {(SUM_W-1){1'b1}}});
	localparam logic signed [SUM_W+1:0] S_MIN = -(SUM_W+2)'({1'b1, {(SUM_W-1){1'b0}}});

	// control state
	logic [2:0]             state_q;
	logic [DCNT_W-1:0]      div_cnt_q;
	logic [CNT_W-1:0]       c_q;
	logic [CNT_W-1:0]       n_q;
	logic [TC_W-1:0]        term_count_q;
	logic                   out_valid_q;

	// datapath registers
	logic                   x_neg_q;
	logic [XMAG_W-1:0]      x_mag_q;
	logic                   t_neg_q;
	logic [MAG_W-1:0]       t_mag_q;
	logic [PROD_W-1:0]      prod_q;
	logic [DVD_W-1:0]       dvd_q;
	logic [CNT_W-1:0]       rem_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                   clip_q;
	logic signed [SUM_W-1:0] exp_sum_q;
	logic                   saturated_q;

	// combinational
	logic                   in_take;
	logic                   out_free;
	logic                   x_neg_d;
	logic [XMAG_W-1:0]      x_mag_d;
	logic [CNT_W-1:0]       n_d;
	logic [RND_W-1:0]       rnd_sum;
	logic [DVD_W-1:0]       dvd_step;
	logic [CNT_W-1:0]       rem_step;
	logic                   r_neg;
	logic [MAG_W-1:0]       new_mag;
	logic                   t_clip;
	logic signed [SUM_W:0]  term_s;
	logic signed [SUM_W+1:0] sum_wide;
	logic signed [SUM_W-1:0] new_sum;
	logic                   s_clip;

	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign exp_sum   = exp_sum_q;
	assign saturated = saturated_q;

	// sign and magnitude of x, term limit
	always_comb begin
		x_neg_d = x_value[X_W-1];
		x_mag_d = x_neg_d ? XMAG_W'(-x_value) : XMAG_W'(x_value);
		if (CMP_W'(term_count_q) > CMP_W'(MAX_TERMS)) begin
			n_d = CNT_W'(MAX_TERMS);
		end else begin
			n_d = CNT_W'(term_count_q);
		end
	end

	// round to nearest on the fraction bits, then divide by c
	assign rnd_sum = {1'b0, prod_q} + (RND_W'(c_q) << (FRAC_BITS - 1));

	// four restoring division steps a cycle on the narrow remainder
	always_comb begin
		logic [CNT_W:0] r_ext;
		dvd_step = dvd_q;
		rem_step = rem_q;
		for (int i = 0; i < DIV_STEP; i++) begin
			r_ext    = {rem_step, dvd_step[DVD_W-1]};
			dvd_step = {dvd_step[DVD_W-2:0], 1'b0};
			if (r_ext >= {1'b0, c_q}) begin
				r_ext       = r_ext - {1'b0, c_q};
				dvd_step[0] = 1'b1;
			end
			rem_step = r_ext[CNT_W-1:0];
		end
	end

	// term clamp and sum update from the finished quotient
	always_comb begin
		r_neg = (t_neg_q != x_neg_q) && (dvd_q != '0);
		t_clip = 1'b0;
		new_mag = MAG_W'(dvd_q);
		if (!r_neg && (dvd_q > Q_POS_MAX)) begin
			new_mag = MAG_W'(Q_POS_MAX);
			t_clip  = 1'b1;
		end else if (r_neg && (dvd_q > Q_NEG_MAX)) begin
			new_mag = MAG_W'(Q_NEG_MAX);
			t_clip  = 1'b1;
		end
		term_s = r_neg ? -$signed({1'b0, new_mag}) : $signed({1'b0, new_mag});
		sum_wide = (SUM_W+2)'(sum_q) + (SUM_W+2)'(term_s);
		s_clip = 1'b0;
		new_sum = SUM_W'(sum_wide);
		if (sum_wide > S_MAX) begin
			new_sum = SUM_W'(S_MAX);
			s_clip  = 1'b1;
		end else if (sum_wide < S_MIN) begin
			new_sum = SUM_W'(S_MIN);
			s_clip  = 1'b1;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q <= TC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			term_count_q <= term_count;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_cnt_q   <= '0;
			c_q         <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register loads a finished result or empties on a take
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						c_q     <= CNT_W'(1);
						n_q     <= n_d;
						state_q <= (n_d == '0) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					div_cnt_q <= DCNT_W'(DIV_CYC - 1);
					state_q   <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_UPD;
					end else begin
						div_cnt_q <= div_cnt_q - DCNT_W'(1);
					end
				end
				ST_UPD: begin
					if (c_q == n_q) begin
						state_q <= ST_FIN;
					end else begin
						c_q     <= c_q + CNT_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					x_neg_q <= x_neg_d;
					x_mag_q <= x_mag_d;
					t_neg_q <= 1'b0;
					t_mag_q <= ONE_MAG;
					sum_q   <= $signed(ONE_MAG);
					clip_q  <= 1'b0;
				end
			end
			ST_MUL: begin
				// shared multiplier, |term| * |x|
				prod_q <= PROD_W'(t_mag_q) * PROD_W'(x_mag_q);
			end
			ST_LOAD: begin
				dvd_q <= DVD_W'(rnd_sum >> FRAC_BITS);
				rem_q <= '0;
			end
			ST_DIV: begin
				dvd_q <= dvd_step;
				rem_q <= rem_step;
			end
			ST_UPD: begin
				t_neg_q <= r_neg;
				t_mag_q <= new_mag;
				sum_q   <= new_sum;
				clip_q  <= clip_q | t_clip | s_clip;
			end
			ST_FIN: begin
				if (out_free) begin
					exp_sum_q   <= sum_q;
					saturated_q <= clip_q;
				end
			end
			default: begin
			end
		endcase
	end

	// checks on the sequencer and datapath
	a_take_then_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> in_stall)
		else $error("input request taken but block not busy");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL || state_q == ST_LOAD || state_q == ST_DIV || state_q == ST_UPD)
		|-> (c_q != '0 && c_q <= n_q))
		else $error("term index outside series range");

	a_term_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (t_mag_q <= MAG_W'(Q_NEG_MAX)))
		else $error("running term magnitude beyond clamp");

endmodule

// ----- test/exp_series_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exp_series_checker: result predictor and comparator for the series core
// follows term-count writes, predicts each e^x sum from accepted requests
// and compares every accepted result in order against the predicted one
// ----------------------------------------------------------------------------
module exp_series_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic signed [ets_pkg::X_W-1:0]    x_value,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic signed [ets_pkg::SUM_W-1:0]  exp_sum,
	input  logic                              saturated,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic        [ets_pkg::TC_W-1:0]   term_count,
	output int                                fail_count,
	output int                                pending,
	output int                                result_count
);

	typedef struct packed {
		logic signed [ets_pkg::SUM_W-1:0] sum;
		logic                             clip;
	} exp_result_t;

	logic [ets_pkg::TC_W-1:0] terms_now;
	exp_result_t              sums_due[$];

	// clamp to the signed 32-bit range, flagging any clip
	function automatic longint clip32(input longint v, inout bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// running term: term = round(term * x / c), summed for c = 1..n
	function automatic exp_result_t exp_series(input logic signed [ets_pkg::X_W-1:0] x,
			input logic [ets_pkg::TC_W-1:0] n);
		longint            x_l, term, sum, v;
		longint unsigned   x_mag, t_mag, den, q;
		bit                x_neg, t_neg, r_neg, clip;
		int                lim;
		exp_result_t       r;
		x_l   = x;
		x_neg = x_l < 0;
		x_mag = x_neg ? longint'(-x_l) : x_l;
		term  = longint'(1) << ets_pkg::FRAC_BITS;
		sum   = term;
		clip  = 1'b0;
		lim   = (n > ets_pkg::MAX_TERMS) ? ets_pkg::MAX_TERMS : int'(n);
		for (int c = 1; c <= lim; c++) begin
			t_neg = term < 0;
			t_mag = t_neg ? longint'(-term) : term;
			den   = longint'(c) << ets_pkg::FRAC_BITS;
			q     = (t_mag * x_mag + den / 2) / den;
			r_neg = (t_neg != x_neg) && (q != 0);
			if (q > (64'd1 << 31))
				q = 64'd1 << 32;
			v    = r_neg ? -longint'(q) : longint'(q);
			term = clip32(v, clip);
			sum  = clip32(sum + term, clip);
		end
		r.sum  = sum[ets_pkg::SUM_W-1:0];
		r.clip = clip;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		exp_result_t want;
		if (!arst_n) begin
			sums_due.delete();
			terms_now    = ets_pkg::TC_RESET;
			fail_count   = 0;
			result_count = 0;
			pending      = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				terms_now = term_count;
			if (in_valid && !in_stall)
				sums_due.push_back(exp_series(x_value, terms_now));
			if (out_valid && !out_stall) begin
				result_count++;
				if (sums_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("[%0t] unexpected result sum=%0d sat=%0b",
							$time, exp_sum, saturated);
				end else begin
					want = sums_due.pop_front();
					if (want.sum !== exp_sum || want.clip !== saturated) begin
						fail_count++;
						if (fail_count <= 10)
							$display("[%0t] mismatch: sum exp %0d got %0d, sat exp %0b got %0b",
								$time, want.sum, exp_sum, want.clip, saturated);
					end
				end
			end
			pending = sums_due.size();
		end
	end

endmodule

// ----- test/tb_exp_taylor_series_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_exp_taylor_series_core: testbench for the exponential series core
// drives directed and random x requests over several term counts with
// random idling on both channels; a checker beside the block predicts and
// compares every result
// ----------------------------------------------------------------------------
module tb_exp_taylor_series_core;

	logic                              clk;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_stall;
	logic signed [ets_pkg::X_W-1:0]    x_value;
	logic                              out_valid;
	logic                              out_stall;
	logic signed [ets_pkg::SUM_W-1:0]  exp_sum;
	logic                              saturated;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic        [ets_pkg::TC_W-1:0]   term_count;

	int fail_count;
	int pending;
	int result_count;

	// idle percentages of sender and receiver, changed per phase
	int send_idle = 31;
	int recv_idle = 63;
	int sent_count;
	int setting_count;

	exp_taylor_series_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.x_value    (x_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.exp_sum    (exp_sum),
		.saturated  (saturated),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.term_count (term_count)
	);

	exp_series_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.x_value      (x_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.exp_sum      (exp_sum),
		.saturated    (saturated),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.term_count   (term_count),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	// 20 ns clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// receiver: random stall decided at each falling edge
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < recv_idle);
		end
	end

	// one x request; entered and left at a falling edge
	task automatic push_x(input logic signed [ets_pkg::X_W-1:0] x);
		// optional sender gap before the request
		while ($urandom_range(99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		x_value  = x;
		// payload held until the block stops stalling
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
		sent_count++;
	endtask

	// wait until every predicted result has come back
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// term-count write, only issued while the block is idle
	task automatic set_terms(input logic [ets_pkg::TC_W-1:0] n);
		cfg_valid  = 1'b1;
		term_count = n;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		setting_count++;
	endtask

	initial begin
		logic signed [ets_pkg::X_W-1:0] edge_x[8];
		logic signed [ets_pkg::X_W-1:0] rx;
		logic [ets_pkg::TC_W-1:0]       n;
		edge_x = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd1, -16'sd1,
			16'sd4096, -16'sd4096, 16'sd8192};
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		x_value    = '0;
		cfg_valid  = 1'b0;
		term_count = ets_pkg::TC_RESET;
		sent_count    = 0;
		setting_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes of x and values around zero and one under the reset term count of ten
		foreach (edge_x[i])
			push_x(edge_x[i]);

		// zero count: result must be exactly one
		drain();
		set_terms('0);
		push_x(16'sd32767);
		push_x(-16'sd32768);
		push_x(16'sd0);

		// full count of 31 terms at the x extremes, around zero and at plus or minus one
		drain();
		set_terms(5'd31);
		push_x(16'sd32767);
		push_x(-16'sd32768);
		push_x(-16'sd1);
		push_x(16'sd1);
		push_x(16'sd4096);
		push_x(-16'sd4096);

		// single term: 1 + x
		drain();
		set_terms(5'd1);
		push_x(16'sd32767);
		push_x(-16'sd32768);

		// random phases: sender/receiver idling, then swapped, then none
		for (int phase = 0; phase < 9; phase++) begin
			drain();
			case (phase / 3)
				0: begin
					send_idle = 31;
					recv_idle = 63;
				end
				1: begin
					send_idle = 63;
					recv_idle = 31;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			// longest count once per idling mode, zero once, else small counts
			if (phase % 3 == 0)
				n = 5'd31;
			else if (phase == 4)
				n = '0;
			else
				n = ets_pkg::TC_W'($urandom_range(1, 12));
			set_terms(n);
			repeat (50) begin
				// mix of full-range, near-zero and near-limit exponents
				case ($urandom_range(3))
					0, 1: rx = ets_pkg::X_W'($urandom);
					2: rx = ets_pkg::X_W'(ets_pkg::X_W'($urandom_range(0, 8192))
						* ($urandom_range(1) ? 1 : -1));
					default: rx = $urandom_range(1)
						? ets_pkg::X_W'(32767 - $urandom_range(0, 255))
						: ets_pkg::X_W'(-32768 + $urandom_range(0, 255));
				endcase
				push_x(rx);
			end
		end

		// let the last results out, then a short quiet tail
		drain();
		repeat (50) @(negedge clk);

		$display("run covered %0d x requests and %0d results", sent_count, result_count);
		$display("over %0d term-count writes, including counts 0, 1 and 31", setting_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
